// ===== sv/fcd_pkg.sv =====
package fcd_pkg;

  localparam int CFG_W  = 11;
  localparam int DATA_W = 8;
  localparam int X_W    = 10;
  localparam int Y_W    = 10;
  localparam int IDX_W  = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic signed [DATA_W-1:0] OCC_UNKNOWN = -8'sd1;
  localparam logic signed [DATA_W-1:0] OCC_FREE    = 8'sd0;

  // bit positions inside a line cell
  localparam int CELL_UNK  = 0;
  localparam int CELL_CAND = 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [1:0] {
    SIDE_ABOVE = 2'd0,
    SIDE_RIGHT = 2'd1,
    SIDE_BELOW = 2'd2,
    SIDE_LEFT  = 2'd3
  } side_t;

  typedef enum logic {
    REG_GRID_COLUMNS = 1'b0,
    REG_GRID_ROWS    = 1'b1
  } reg_idx_t;

  // one line store entry: unknown flag of the row above, pending-row cell
  typedef struct packed {
    logic       above_unk;
    logic [1:0] pend;
  } line_entry_t;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    side_t            side;
    logic [IDX_W-1:0] idx;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;   // 0, 1 or 2 results this cycle
    result_t    a;     // first result
    result_t    b;     // second result (only when cnt is 2)
  } push_t;

endpackage

// ===== sv/fcd_line_mem.sv =====
module fcd_line_mem
  import fcd_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  line_entry_t      wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output line_entry_t      rd_data_a,
  output line_entry_t      rd_data_b
);

  line_entry_t mem [DEPTH];
  line_entry_t rd_a_r;
  line_entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write; the caller forwards same-address hits
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== sv/fcd_out_fifo.sv =====
module fcd_out_fifo
  import fcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room2,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t              ent [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW:0]     count_r;
  logic [FIFO_AW:0]     count_nxt;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign out_data  = ent[rd_ptr_r];
  assign room2     = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_nxt = count_r + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent[wr_ptr_r] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      ent[wr_ptr_r + FIFO_AW'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push.cnt);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/frontier_cell_detector.sv =====
// Frontier cell detector, von Neumann neighborhood.
// Input channel (in_*): one occupancy-grid cell per transaction, raster order,
// top row first, columns ascending. After the last grid row send one flush
// row of cells (pad bit set) to decide the last row and close the frame.
// Output channel (out_*): one transaction per frontier cell (x, y, first
// unknown side, running index), and after the flush row one transaction with
// frame_end set carrying the frame's frontier total in frontier_index.
// Config channel (cfg_*): index 0 grid_columns, index 1 grid_rows; always
// ready. Write only while the block is idle.
// Throughput: one cell per clock while in_stall is low. A cell row is decided
// when the cell below it arrives, so a frontier shows on out_* only after the
// cell below it was accepted; a transaction's results wait in stage 1 and
// enter the queue when stage 1 fires. The line store is one dual-read memory.
// Reset: the line store is swept to zero, one entry per cycle, all MAX_COLUMNS
// entries; in_stall stays high during the sweep. Config returns to 1024/1024.
// Receiver stall: results sit in a 4-entry queue; once it cannot take two
// more results the pipeline holds and in_stall rises.
module frontier_cell_detector
  import fcd_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int COUNT_LIMIT = 65535
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // cell input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_occupancy,
  input  logic signed [DATA_W-1:0] in_cost,
  input  logic                     in_pad,
  // results
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [X_W-1:0]           out_cell_x,
  output logic [Y_W-1:0]           out_cell_y,
  output logic [1:0]               out_side,
  output logic [IDX_W-1:0]         out_frontier_index,
  output logic                     out_frame_end,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int AW     = $clog2(MAX_COLUMNS);
  localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROWS_W = $clog2(MAX_ROWS + 2);
  localparam int CCMP_W = (COLS_W > CFG_W) ? COLS_W : CFG_W;
  localparam int RCMP_W = (ROWS_W > CFG_W) ? ROWS_W : CFG_W;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] grid_columns_r;
  logic [CFG_W-1:0] grid_rows_r;
  logic [CCMP_W-1:0] gc_ext;
  logic [RCMP_W-1:0] gr_ext;
  logic [COLS_W-1:0] cols;
  logic [ROWS_W-1:0] rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= CFG_RESET;
      grid_rows_r    <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_COLUMNS: grid_columns_r <= cfg_data;
        REG_GRID_ROWS:    grid_rows_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes into 1..MAX
  always_comb begin
    gc_ext = CCMP_W'(grid_columns_r);
    gr_ext = RCMP_W'(grid_rows_r);
    if (gc_ext == '0) begin
      cols = COLS_W'(1);
    end else if (gc_ext > CCMP_W'(MAX_COLUMNS)) begin
      cols = COLS_W'(MAX_COLUMNS);
    end else begin
      cols = gc_ext[COLS_W-1:0];
    end
    if (gr_ext == '0) begin
      rows = ROWS_W'(1);
    end else if (gr_ext > RCMP_W'(MAX_ROWS)) begin
      rows = ROWS_W'(MAX_ROWS);
    end else begin
      rows = gr_ext[ROWS_W-1:0];
    end
  end

  // ---------------------------------------------------------- clear sweep
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(MAX_COLUMNS - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // ------------------------------------------------ stage 0: position, read
  logic [AW-1:0]     col_r;
  logic [ROWS_W-1:0] row_r;
  logic [AW-1:0]     col_nxt;
  logic [ROWS_W-1:0] row_nxt;
  logic              in_acc;
  logic              wrap;
  logic [AW-1:0]     c0;
  logic [ROWS_W-1:0] r0;
  logic [ROWS_W-1:0] r0_pre;
  logic [COLS_W-1:0] c_plus;
  logic              last_col;
  logic              at_flush;
  logic              in_grid;
  logic [1:0]        cell0;
  logic [ROWS_W-1:0] y_full;
  logic [31:0]       y_wide;
  logic              s0_close;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    wrap   = (COLS_W'(col_r) >= cols);
    c0     = wrap ? '0 : col_r;
    r0_pre = wrap ? (row_r + ROWS_W'(1)) : row_r;
    r0     = (r0_pre > rows) ? '0 : r0_pre;

    c_plus   = COLS_W'(c0) + COLS_W'(1);
    last_col = (c_plus >= cols);
    at_flush = (r0 == rows);
    s0_close = last_col && at_flush;

    col_nxt = last_col ? '0 : c_plus[AW-1:0];
    if (!last_col) begin
      row_nxt = r0;
    end else if (at_flush) begin
      row_nxt = '0;
    end else begin
      row_nxt = r0 + ROWS_W'(1);
    end

    in_grid = (r0 < rows) && !in_pad;
    cell0[CELL_UNK]  = in_grid && (in_occupancy == OCC_UNKNOWN);
    cell0[CELL_CAND] = in_grid && (in_occupancy == OCC_FREE) && (in_cost == OCC_FREE);

    y_full = rows - r0;
    y_wide = 32'(y_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------- stage 1 registers
  logic          s1_valid_r;
  logic [AW-1:0] s1_c_r;
  logic [Y_W-1:0] s1_y_r;
  logic [1:0]    s1_cell_r;
  logic          s1_rzero_r;
  logic          s1_right_ok_r;
  logic          s1_left_ok_r;
  logic          s1_close_r;
  logic          s1_fire;
  logic          fifo_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_c_r        <= c0;
      s1_y_r        <= y_wide[Y_W-1:0];
      s1_cell_r     <= cell0;
      s1_rzero_r    <= (r0 == '0);
      s1_right_ok_r <= !last_col;
      s1_left_ok_r  <= (c0 != '0);
      s1_close_r    <= s0_close;
    end
  end

  assign s1_fire  = s1_valid_r && fifo_room;
  assign in_stall = clr_active_r || (s1_valid_r && !s1_fire);

  // ------------------------------------------------------------ line store
  line_entry_t rd_a;
  line_entry_t rd_b;
  line_entry_t s1_wr_data;
  line_entry_t mem_wr_data;
  logic [AW-1:0] mem_wr_addr;
  logic          mem_wr_en;

  assign mem_wr_en   = clr_active_r || s1_fire;
  assign mem_wr_addr = clr_active_r ? clr_addr_r : s1_c_r;
  assign mem_wr_data = clr_active_r ? line_entry_t'('0) : s1_wr_data;

  fcd_line_mem #(
    .DEPTH (MAX_COLUMNS),
    .AW    (AW)
  ) u_line_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (in_acc),
    .rd_addr_a (c0),
    .rd_addr_b (c_plus[AW-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // forward the write of the item leaving stage 1 to the read issued at the
  // same edge
  logic        byp_a_r;
  logic        byp_b_r;
  line_entry_t byp_data_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_a_r    <= s1_fire && (s1_c_r == c0);
      byp_b_r    <= s1_fire && (s1_c_r == c_plus[AW-1:0]);
      byp_data_r <= s1_wr_data;
    end
  end

  // ------------------------------------------------- stage 1: decide cell
  line_entry_t      ent_a;
  logic [1:0]       b_cell;
  logic [1:0]       mid;
  logic             up;
  logic             right;
  logic             down;
  logic             left;
  logic             hit;
  side_t            side;
  logic [1:0]       left_cell_r;
  logic [IDX_W-1:0] fc_r;
  logic [IDX_W-1:0] fc_after;
  logic [31:0]      x_wide;
  result_t          res_front;
  result_t          res_end;
  push_t            push;

  always_comb begin
    ent_a  = byp_a_r ? byp_data_r : rd_a;
    b_cell = byp_b_r ? byp_data_r.pend : rd_b.pend;
    mid    = ent_a.pend;

    up    = ent_a.above_unk;
    right = s1_right_ok_r && b_cell[CELL_UNK];
    down  = s1_cell_r[CELL_UNK];
    left  = s1_left_ok_r && left_cell_r[CELL_UNK];

    if (up) begin
      side = SIDE_ABOVE;
    end else if (right) begin
      side = SIDE_RIGHT;
    end else if (down) begin
      side = SIDE_BELOW;
    end else begin
      side = SIDE_LEFT;
    end
    hit = !s1_rzero_r && mid[CELL_CAND] && (up || right || down || left);

    // row 0 has nothing above; pending row moves up
    s1_wr_data.above_unk = s1_rzero_r ? 1'b0 : mid[CELL_UNK];
    s1_wr_data.pend      = s1_cell_r;

    fc_after = (hit && (fc_r < IDX_W'(COUNT_LIMIT))) ? (fc_r + IDX_W'(1)) : fc_r;

    x_wide              = 32'(s1_c_r);
    res_front.x         = x_wide[X_W-1:0];
    res_front.y         = s1_y_r;
    res_front.side      = side;
    res_front.idx       = fc_r;
    res_front.frame_end = 1'b0;

    res_end.x         = '0;
    res_end.y         = '0;
    res_end.side      = SIDE_ABOVE;
    res_end.idx       = fc_after;
    res_end.frame_end = 1'b1;

    push.cnt = 2'd0;
    push.a   = res_front;
    push.b   = res_end;
    if (s1_fire) begin
      push.cnt = 2'(hit) + 2'(s1_close_r);
      if (!hit) begin
        push.a = res_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      left_cell_r <= '0;
    end else if (s1_fire) begin
      fc_r        <= s1_close_r ? '0 : fc_after;
      left_cell_r <= mid;
    end
  end

  // ---------------------------------------------------------- result queue
  result_t out_data;

  fcd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (fifo_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_cell_x         = out_data.x;
  assign out_cell_y         = out_data.y;
  assign out_side           = out_data.side;
  assign out_frontier_index = out_data.idx;
  assign out_frame_end      = out_data.frame_end;

endmodule

// ===== sv/fcd_checker.sv =====
module fcd_checker
  import fcd_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic signed [DATA_W-1:0] in_occupancy,
  input logic signed [DATA_W-1:0] in_cost,
  input logic                     in_pad,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [X_W-1:0]           out_cell_x,
  input logic [Y_W-1:0]           out_cell_y,
  input logic [1:0]               out_side,
  input logic [IDX_W-1:0]         out_frontier_index,
  input logic                     out_frame_end,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic                     cfg_index,
  input logic [CFG_W-1:0]         cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_x) && $stable(out_cell_y)
      && $stable(out_side) && $stable(out_frontier_index) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // line store sweep blocks input right after reset
  a_sweep_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during line store sweep");

  // nothing queued after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // frame close carries only the count
  a_close_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_cell_x == '0 && out_cell_y == '0 && out_side == 2'd0)
    else $error("frame close with nonzero position");

  // consecutive frontiers of one frame are numbered in sequence or saturate
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_frame_end
      ##1 out_valid && !out_frame_end && $past(out_frontier_index) != 16'hFFFF
    |-> out_frontier_index == $past(out_frontier_index) + 16'd1
      || out_frontier_index == $past(out_frontier_index)
      || out_frontier_index == '0)
    else $error("frontier index out of sequence");

endmodule

bind frontier_cell_detector fcd_checker u_fcd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_occupancy       (in_occupancy),
  .in_cost            (in_cost),
  .in_pad             (in_pad),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_cell_x         (out_cell_x),
  .out_cell_y         (out_cell_y),
  .out_side           (out_side),
  .out_frontier_index (out_frontier_index),
  .out_frame_end      (out_frame_end),
  .cfg_valid          (cfg_valid),
  .cfg_ready          (cfg_ready),
  .cfg_index          (cfg_index),
  .cfg_data           (cfg_data)
);
